// ===== sv/accumulator_cpu_step_top_macros.svh =====
// Assertion helpers shared by the controller and the datapath.
// Both expect clk and arst_n in scope.
`ifndef ACCUMULATOR_CPU_STEP_TOP_MACROS_SVH
`define ACCUMULATOR_CPU_STEP_TOP_MACROS_SVH

// same-cycle implication
`define ACS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ACS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/acs_pkg.sv =====
package acs_pkg;

	localparam int DW    = 8;
	localparam int IN_W  = 24;
	localparam int OUT_W = 40;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_EXEC  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_code_t;

	localparam logic [7:0] OP_HLT   = 8'h00;
	localparam logic [7:0] OP_LOAD  = 8'h01;
	localparam logic [7:0] OP_STORE = 8'h02;
	localparam logic [7:0] OP_ADD   = 8'h03;
	localparam logic [7:0] OP_SUB   = 8'h04;
	localparam logic [7:0] OP_MUL   = 8'h05;
	localparam logic [7:0] OP_DIV   = 8'h06;
	localparam logic [7:0] OP_CMP   = 8'h07;
	localparam logic [7:0] OP_LAST  = OP_CMP;

	typedef enum logic [2:0] {
		ST_RUN   = 3'd0,
		ST_HALT  = 3'd1,
		ST_BADOP = 3'd2,
		ST_RANGE = 3'd3,
		ST_DIVZ  = 3'd4
	} stop_t;

	typedef enum logic [1:0] {
		CMP_NONE    = 2'd0,
		CMP_EQ      = 2'd1,
		CMP_LESS    = 2'd2,
		CMP_GREATER = 2'd3
	} cmp_t;

	typedef enum logic [2:0] {
		MEM_IDLE   = 3'd0,
		MEM_CLEAR  = 3'd1,
		MEM_WR_IN  = 3'd2,
		MEM_RD_IN  = 3'd3,
		MEM_RD_PC  = 3'd4,
		MEM_WR_LOC = 3'd5,
		MEM_RD_LOC = 3'd6
	} mem_op_t;

	typedef struct packed {
		mem_op_t mem_op;
		logic    in_load;
		logic    op_load;
		logic    lo_load;
		logic    rd_capture;
		logic    exec;
		logic    div_start;
		logic    div_wb;
		logic    set_st;
		stop_t   st_code;
		logic    out_load;
	} ctl_cmd_t;

	typedef struct packed {
		cmd_code_t cmd;
		logic      in_addr_ok;
		logic      pc_ok;
		logic      loc_ok;
		logic      stopped;
		logic      rd_halt;
		logic      rd_bad;
		logic      op_store;
		logic      op_div;
		logic      m_zero;
		logic      div_done;
		logic      clr_last;
		logic      out_free;
	} ctl_sts_t;

endpackage

// ===== sv/accumulator_cpu_step_top.sv =====
// 8-bit accumulator machine, one command per transaction.
// Slave channel (s_*): one command per transaction; tuser carries the command
// (write byte, read byte, execute one instruction), tdata the address and data.
// Master channel (m_*): exactly one result transaction per command, carrying
// stop status, accumulator, compare state, code pointer and read byte.
// A command passes through the sequencer in order: decode, then the read
// capture for a read; for a step on a running machine the serial memory port
// (three fetch reads and one data access), execute and, for a divide, the
// bit-serial divider; last the result load. One command is in flight at a
// time, so a new one is taken only after the previous result is loaded.
// After reset the byte memory is cleared one entry a cycle, and s_tready
// stays low until that sweep ends; the accumulator, code pointer, compare
// state and stop status reset to zero with the machine running.
// The result sits in an output register: with m_tready low a new command is
// still taken, and its result waits until the previous transaction is taken.
module accumulator_cpu_step_top
	import acs_pkg::*;
#(
	parameter int MEM_SIZE = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // address[15:0], write_data[23:16]
	input  logic [1:0]       s_tuser,  // command[1:0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // status[2:0], acc_value[10:3],
	                                   // compare_result[12:11],
	                                   // code_pointer[28:13], read_data[36:29]
);

	ctl_cmd_t ctl;
	ctl_sts_t sts;

	// sequencer: walks clear, fetch, execute and result steps
	acs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// memory, machine registers, ALU, divider and output register
	acs_dpath #(
		.MEM_SIZE (MEM_SIZE)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== sv/acs_div.sv =====
module acs_div
	import acs_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW);
	localparam logic [CW-1:0] CNT_INIT = CW'(DW - 1);

	logic [DW-1:0] rem_q, quo_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [DW:0]   rem_sh, diff;
	logic          ge;

	// restoring divide, one quotient bit a cycle
	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign ge     = rem_sh >= {1'b0, dvs_q};
	assign diff   = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_INIT;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== sv/acs_dpath.sv =====
module acs_dpath
	import acs_pkg::*;
#(
	parameter int MEM_SIZE = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	input  ctl_cmd_t         ctl,
	output ctl_sts_t         sts,
	input  logic [IN_W-1:0]  s_tdata,
	input  logic [1:0]       s_tuser,
	input  logic             m_tready,
	output logic             m_tvalid,
	output logic [OUT_W-1:0] m_tdata
);

`include "accumulator_cpu_step_top_macros.svh"

	localparam int AW = $clog2(MEM_SIZE);
	localparam logic [16:0]   ADDR_LIM = 17'(MEM_SIZE);
	localparam logic [AW-1:0] CLR_LAST = AW'(MEM_SIZE - 1);

	logic [DW-1:0] mem [MEM_SIZE];

	cmd_code_t     in_cmd_q;
	logic [15:0]   in_addr_q;
	logic [DW-1:0] in_wdata_q;
	logic [DW-1:0] rd_q, op_q, lo_q, read_q;
	logic [DW-1:0] acc_q;
	logic [15:0]   pc_q;
	cmp_t          cmp_q;
	stop_t         stop_q;
	logic [AW-1:0] clr_cnt_q;
	logic          m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	logic [15:0]   loc;
	logic [AW-1:0] mem_addr;
	logic [DW-1:0] mem_wdata;
	logic          mem_we, mem_re;
	logic [DW-1:0] acc_n;
	cmp_t          cmp_n;
	logic [2*DW-1:0] prod;
	logic          div_done;
	logic [DW-1:0] div_quo;

	assign loc = {rd_q, lo_q};

	// single memory port
	always_comb begin
		mem_addr  = in_addr_q[AW-1:0];
		mem_wdata = in_wdata_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		case (ctl.mem_op)
			MEM_CLEAR: begin
				mem_addr  = clr_cnt_q;
				mem_wdata = '0;
				mem_we    = 1'b1;
			end
			MEM_WR_IN: mem_we = 1'b1;
			MEM_RD_IN: mem_re = 1'b1;
			MEM_RD_PC: begin
				mem_addr = pc_q[AW-1:0];
				mem_re   = 1'b1;
			end
			MEM_WR_LOC: begin
				mem_addr  = loc[AW-1:0];
				mem_wdata = acc_q;
				mem_we    = 1'b1;
			end
			MEM_RD_LOC: begin
				mem_addr = loc[AW-1:0];
				mem_re   = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wdata;
		if (mem_re)
			rd_q <= mem[mem_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_cnt_q <= '0;
		else if (ctl.mem_op == MEM_CLEAR)
			clr_cnt_q <= clr_cnt_q + 1'b1;
	end

	// ALU, rd_q holds the memory operand during execute
	assign prod = acc_q * rd_q;

	always_comb begin
		acc_n = acc_q;
		cmp_n = cmp_q;
		case (op_q)
			OP_LOAD: acc_n = rd_q;
			OP_ADD:  acc_n = acc_q + rd_q;
			OP_SUB:  acc_n = acc_q - rd_q;
			OP_MUL:  acc_n = prod[DW-1:0];
			OP_CMP: begin
				if (rd_q == acc_q)
					cmp_n = CMP_EQ;
				else if (rd_q < acc_q)
					cmp_n = CMP_LESS;
				else
					cmp_n = CMP_GREATER;
			end
			default: ;
		endcase
	end

	acs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (acc_q),
		.divisor  (rd_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pc_q   <= '0;
			cmp_q  <= CMP_NONE;
			stop_q <= ST_RUN;
		end else begin
			if (ctl.mem_op == MEM_RD_PC)
				pc_q <= pc_q + 16'd1;
			if (ctl.exec) begin
				acc_q <= acc_n;
				cmp_q <= cmp_n;
			end
			if (ctl.div_wb)
				acc_q <= div_quo;
			if (ctl.set_st)
				stop_q <= ctl.st_code;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.in_load) begin
			in_cmd_q   <= cmd_code_t'(s_tuser);
			in_addr_q  <= s_tdata[15:0];
			in_wdata_q <= s_tdata[23:16];
			read_q     <= '0;
		end
		if (ctl.rd_capture)
			read_q <= rd_q;
		if (ctl.op_load)
			op_q <= rd_q;
		if (ctl.lo_load)
			lo_q <= rd_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (ctl.out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load)
			m_tdata_q <= {3'b000, read_q, pc_q, cmp_q, acc_q, stop_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		sts            = '0;
		sts.cmd        = in_cmd_q;
		sts.in_addr_ok = {1'b0, in_addr_q} < ADDR_LIM;
		sts.pc_ok      = {1'b0, pc_q} < ADDR_LIM;
		sts.loc_ok     = {1'b0, loc} < ADDR_LIM;
		sts.stopped    = stop_q != ST_RUN;
		sts.rd_halt    = rd_q == OP_HLT;
		sts.rd_bad     = rd_q > OP_LAST;
		sts.op_store   = op_q == OP_STORE;
		sts.op_div     = op_q == OP_DIV;
		sts.m_zero     = rd_q == '0;
		sts.div_done   = div_done;
		sts.clr_last   = clr_cnt_q == CLR_LAST;
		sts.out_free   = !m_tvalid_q || m_tready;
	end

	`ACS_ASSERT_NXT(a_stop_sticky, stop_q != ST_RUN, stop_q != ST_RUN, "stop status left its sticky value")
	`ACS_ASSERT_NXT(a_pc_fetch_only, ctl.mem_op != MEM_RD_PC, $stable(pc_q), "code pointer moved without a fetch")
	`ACS_ASSERT_IMP(a_store_in_range, ctl.mem_op == MEM_WR_LOC, sts.loc_ok, "store to an out-of-range location")

endmodule

// ===== sv/acs_ctrl.sv =====
module acs_ctrl
	import acs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  ctl_sts_t sts,
	output ctl_cmd_t ctl
);

`include "accumulator_cpu_step_top_macros.svh"

	typedef enum logic [10:0] {
		S_CLEAR    = 11'h001,
		S_IDLE     = 11'h002,
		S_DECODE   = 11'h004,
		S_READ_CAP = 11'h008,
		S_FETCH_OP = 11'h010,
		S_OPCODE   = 11'h020,
		S_FETCH_HI = 11'h040,
		S_LOCATE   = 11'h080,
		S_EXEC     = 11'h100,
		S_DIV      = 11'h200,
		S_RESP     = 11'h400
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_CLEAR: begin
				ctl.mem_op = MEM_CLEAR;
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					ctl.in_load = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_RESP;
				case (sts.cmd)
					CMD_WRITE: begin
						if (sts.in_addr_ok)
							ctl.mem_op = MEM_WR_IN;
					end
					CMD_READ: begin
						if (sts.in_addr_ok) begin
							ctl.mem_op = MEM_RD_IN;
							state_d    = S_READ_CAP;
						end
					end
					CMD_EXEC: begin
						if (!sts.stopped)
							state_d = S_FETCH_OP;
					end
					default: ;
				endcase
			end
			S_READ_CAP: begin
				ctl.rd_capture = 1'b1;
				state_d        = S_RESP;
			end
			S_FETCH_OP: begin
				if (sts.pc_ok) begin
					ctl.mem_op = MEM_RD_PC;
					state_d    = S_OPCODE;
				end else begin
					ctl.set_st  = 1'b1;
					ctl.st_code = ST_RANGE;
					state_d     = S_RESP;
				end
			end
			S_OPCODE: begin
				ctl.op_load = 1'b1;
				if (sts.rd_halt) begin
					ctl.set_st  = 1'b1;
					ctl.st_code = ST_HALT;
					state_d     = S_RESP;
				end else if (sts.rd_bad) begin
					ctl.set_st  = 1'b1;
					ctl.st_code = ST_BADOP;
					state_d     = S_RESP;
				end else if (!sts.pc_ok) begin
					ctl.set_st  = 1'b1;
					ctl.st_code = ST_RANGE;
					state_d     = S_RESP;
				end else begin
					ctl.mem_op = MEM_RD_PC;
					state_d    = S_FETCH_HI;
				end
			end
			S_FETCH_HI: begin
				ctl.lo_load = 1'b1;
				if (sts.pc_ok) begin
					ctl.mem_op = MEM_RD_PC;
					state_d    = S_LOCATE;
				end else begin
					ctl.set_st  = 1'b1;
					ctl.st_code = ST_RANGE;
					state_d     = S_RESP;
				end
			end
			S_LOCATE: begin
				state_d = S_RESP;
				if (!sts.loc_ok) begin
					ctl.set_st  = 1'b1;
					ctl.st_code = ST_RANGE;
				end else if (sts.op_store) begin
					ctl.mem_op = MEM_WR_LOC;
				end else begin
					ctl.mem_op = MEM_RD_LOC;
					state_d    = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_RESP;
				if (!sts.op_div) begin
					ctl.exec = 1'b1;
				end else if (sts.m_zero) begin
					ctl.set_st  = 1'b1;
					ctl.st_code = ST_DIVZ;
				end else begin
					ctl.div_start = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					ctl.div_wb = 1'b1;
					state_d    = S_RESP;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign s_tready = state_q == S_IDLE;

	`ACS_ASSERT_IMP(a_out_free, ctl.out_load, sts.out_free, "result loaded over an untaken one")
	`ACS_ASSERT_IMP(a_div_wb, ctl.div_wb, sts.div_done, "quotient written back before the divide ended")
	`ACS_ASSERT_IMP(a_status_once, ctl.set_st, !sts.stopped, "stop status set on a stopped machine")

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the 8-bit accumulator machine.
//
// Commands go in on the s_* channel: tuser carries the command, tdata the
// address and write byte. Every accepted command produces exactly one result
// transaction on m_*. The bench keeps its own copy of the machine (memory
// image, accumulator, code pointer, compare flag, stop status). It advances
// that copy when a command transaction is accepted, and it queues the report
// the block should send back. A checker pops the oldest report for every
// result transaction and compares it field by field.
//
// The stop status is sticky and reset is only applied once. So the run first
// executes a long random program that never stops the machine. Then it
// triggers a single stop (halt, bad opcode or divide by zero, picked at
// random), and it finishes with random traffic against the stopped machine.
// With the default memory size every address is valid, so the address out of
// range status cannot be reached.
module tb_top
	import acs_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int          MEM_SIZE    = 65536;
	localparam int          CLK_PERIOD  = 10;
	localparam int          CYCLE_LIMIT = 2_000_000; // clear sweep + slowest run, several times over
	localparam int          HOLD_CYCLES = 300;
	localparam int          RUN_TARGET  = 1450;      // commands before the machine is stopped
	localparam int          ALL_TARGET  = 1850;
	localparam logic [15:0] DATA_BASE   = 16'h8000;  // operand area, well clear of the code

	// result fields, lowest bits last in the declaration so a cast of m_tdata lines up
	typedef struct packed {
		logic [7:0]  rd;
		logic [15:0] pc;
		cmp_t        cmp;
		logic [7:0]  acc;
		stop_t       st;
	} report_t;

	// receiver stall patterns
	typedef enum int {RX_FREE, RX_COIN, RX_EVERY4, RX_SPARSE} rx_pattern_t;

	logic            clk      = 1'b0;
	logic            arst_n   = 1'b0;
	logic            s_tvalid = 1'b0;
	logic            s_tready;
	logic [IN_W-1:0] s_tdata  = '0;  // address[15:0], write_data[23:16]
	logic [1:0]      s_tuser  = '0;  // command[1:0]
	logic            m_tvalid;
	logic            m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;       // status[2:0], acc_value[10:3], compare_result[12:11],
	                                 // code_pointer[28:13], read_data[36:29]

	// machine copy kept by the bench
	bit   [7:0]  mem_img [MEM_SIZE];
	logic [7:0]  acc_m    = 8'h00;
	logic [15:0] code_ptr = 16'h0000;
	cmp_t        cmp_m    = CMP_NONE;
	stop_t       mach_st  = ST_RUN;

	report_t pending_reports [$];

	int n_fail     = 0;
	int n_checked  = 0;
	int n_commands = 0;   // commands accepted, of every kind
	int n_steps    = 0;   // instructions actually executed
	int gap_max    = 4;   // longest sender gap, 0 for back-to-back transactions
	int burst_left = 0;
	int hold_req   = 0;   // set by a test to make the receiver hold off
	stop_t stop_seen = ST_RUN;

	accumulator_cpu_step_top #(
		.MEM_SIZE(MEM_SIZE)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ---------------------------------------------------------------------
	// Machine prediction
	// ---------------------------------------------------------------------

	// One code byte at the code pointer; an invalid pointer stops the machine
	// and does not advance.
	function automatic bit fetch_code(output logic [7:0] b);
		b = 8'h00;
		if (code_ptr >= MEM_SIZE) begin
			mach_st = ST_RANGE;
			return 1'b0;
		end
		b = mem_img[code_ptr];
		code_ptr = code_ptr + 16'd1;
		return 1'b1;
	endfunction

	function automatic report_t step_machine(cmd_code_t cmd, logic [15:0] addr,
	                                         logic [7:0] wdata);
		report_t    r;
		logic [7:0] op, lo, hi, m;
		logic [15:0] loc;
		r.rd = 8'h00;
		case (cmd)
			CMD_WRITE: if (addr < MEM_SIZE) mem_img[addr] = wdata;
			CMD_READ:  if (addr < MEM_SIZE) r.rd = mem_img[addr];
			CMD_EXEC: begin
				// a stopped machine ignores steps; the fetch calls short-circuit
				// so a failed fetch ends the step where it stands
				if (mach_st == ST_RUN && fetch_code(op)) begin
					if (op == OP_HLT)
						mach_st = ST_HALT;
					else if (op > OP_LAST)
						mach_st = ST_BADOP;
					else if (fetch_code(lo) && fetch_code(hi)) begin
						loc = {hi, lo};
						if (loc >= MEM_SIZE)
							mach_st = ST_RANGE;
						else if (op == OP_STORE)
							mem_img[loc] = acc_m;
						else begin
							m = mem_img[loc];
							case (op)
								OP_LOAD: acc_m = m;
								OP_ADD:  acc_m = acc_m + m;
								OP_SUB:  acc_m = acc_m - m;
								OP_MUL:  acc_m = acc_m * m;
								OP_DIV: begin
									if (m == 8'h00)
										mach_st = ST_DIVZ;
									else
										acc_m = acc_m / m;
								end
								default: cmp_m = (m == acc_m) ? CMP_EQ :
								                 (m < acc_m)  ? CMP_LESS : CMP_GREATER;
							endcase
						end
					end
				end
			end
			default: ;
		endcase
		r.st  = mach_st;
		r.acc = acc_m;
		r.cmp = cmp_m;
		r.pc  = code_ptr;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Command side
	// ---------------------------------------------------------------------

	// Drives one command transaction at the falling edge, waits for the
	// handshake, then predicts. The sender runs in bursts with random gaps.
	task automatic send_cmd(cmd_code_t cmd, logic [15:0] addr, logic [7:0] wdata);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gap_max > 0) begin
				gap = $urandom_range(1, gap_max);
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {wdata, addr};
		do @(posedge clk); while (!s_tready);
		n_commands++;
		if (cmd == CMD_EXEC && mach_st == ST_RUN)
			n_steps++;
		pending_reports.push_back(step_machine(cmd, addr, wdata));
	endtask

	// Writes opcode and little-endian location at the code pointer, then
	// steps. The spare fields of the step carry random bits.
	task automatic issue_instr(logic [7:0] op, logic [15:0] loc);
		send_cmd(CMD_WRITE, code_ptr, op);
		send_cmd(CMD_WRITE, code_ptr + 16'd1, loc[7:0]);
		send_cmd(CMD_WRITE, code_ptr + 16'd2, loc[15:8]);
		send_cmd(CMD_EXEC, 16'($urandom), 8'($urandom));
	endtask

	// Image traffic with no effect on the program about to run: every code
	// byte is rewritten just before its step.
	task automatic random_noise();
		case ($urandom_range(0, 5))
			0, 1: send_cmd(CMD_READ, 16'($urandom), 8'($urandom));
			2:    send_cmd(CMD_WRITE, 16'($urandom), 8'($urandom));
			3:    send_cmd(CMD_WRITE, 16'(DATA_BASE + $urandom_range(0, 31)), 8'($urandom));
			4:    send_cmd(CMD_NONE, 16'($urandom), 8'($urandom));
			default: send_cmd(CMD_READ, 16'(code_ptr - $urandom_range(0, 8)), 8'($urandom));
		endcase
	endtask

	// A well-formed step that keeps the machine running: operands mostly from
	// a small shared area, sometimes anywhere; divides always see a non-zero
	// byte. Some operands copy the accumulator to hit the equal compare.
	task automatic random_instruction();
		logic [7:0]  op, operand;
		logic [15:0] loc;
		op = 8'($urandom_range(OP_LOAD, OP_CMP));
		repeat ($urandom_range(0, 2)) random_noise();
		if (op != OP_DIV && $urandom_range(0, 3) == 0)
			loc = 16'($urandom);
		else
			loc = 16'(DATA_BASE + $urandom_range(0, 31));
		if (op == OP_DIV || $urandom_range(0, 9) < 7) begin
			operand = ($urandom_range(0, 4) == 0) ? acc_m : 8'($urandom);
			if (op == OP_DIV && operand == 8'h00)
				operand = 8'($urandom_range(1, 255));
			send_cmd(CMD_WRITE, loc, operand);
		end else if (op == OP_DIV && mem_img[loc] == 8'h00) begin
			send_cmd(CMD_WRITE, loc, 8'($urandom_range(1, 255)));
		end
		issue_instr(op, loc);
	endtask

	// ---------------------------------------------------------------------
	// Result side
	// ---------------------------------------------------------------------

	// Stall pattern of its own, picked anew at random when its run length expires;
	// a hold-off request from a test overrides it for a counted stretch.
	initial begin
		rx_pattern_t pattern;
		int          pattern_left;
		int          hold_cnt;
		int          phase;
		pattern      = RX_FREE;
		pattern_left = 0;
		hold_cnt     = 0;
		phase        = 0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				hold_cnt = hold_req;
				hold_req = 0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else begin
				if (pattern_left == 0) begin
					pattern      = rx_pattern_t'($urandom_range(0, 3));
					pattern_left = $urandom_range(20, 200);
				end
				pattern_left--;
				phase++;
				case (pattern)
					RX_FREE:   m_tready <= 1'b1;
					RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
					RX_EVERY4: m_tready <= (phase % 4 == 0);
					default:   m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_fail++;
		end
	endfunction

	always @(posedge clk) begin
		report_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = report_t'(m_tdata[36:0]);
			if (pending_reports.size() == 0) begin
				$error("result transaction with no command outstanding");
				n_fail++;
			end else begin
				want = pending_reports.pop_front();
				check_field("status",         want.st,  got.st);
				check_field("acc_value",      want.acc, got.acc);
				check_field("compare_result", want.cmp, got.cmp);
				check_field("code_pointer",   want.pc,  got.pc);
				check_field("read_data",      want.rd,  got.rd);
				n_checked++;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Cleared memory at both ends, the unused command, a write/read round
	// trip at the top address.
	task automatic test_image_access();
		send_cmd(CMD_READ,  16'h0000, 8'hFF);
		send_cmd(CMD_READ,  16'hFFFF, 8'h00);
		send_cmd(CMD_NONE,  16'hFFFF, 8'hFF);
		send_cmd(CMD_WRITE, 16'hFFFF, 8'hFF);
		send_cmd(CMD_READ,  16'hFFFF, 8'h00);
		send_cmd(CMD_WRITE, DATA_BASE, 8'h01);
	endtask

	// Each opcode but halt once, with wrap-around on add, subtract and multiply and an
	// equal compare after a store.
	task automatic test_each_opcode();
		issue_instr(OP_LOAD,  16'hFFFF);          // acc = FF
		issue_instr(OP_ADD,   DATA_BASE);         // FF + 1 wraps to 00
		issue_instr(OP_SUB,   DATA_BASE);         // 00 - 1 wraps to FF
		issue_instr(OP_MUL,   16'hFFFF);          // FF * FF -> 01
		issue_instr(OP_STORE, DATA_BASE + 16'd1);
		issue_instr(OP_DIV,   DATA_BASE + 16'd1); // 01 / 01
		issue_instr(OP_CMP,   DATA_BASE + 16'd1);
	endtask

	// Receiver holds off while commands keep coming back to back: the output
	// register and the one command in flight fill up and s_tready drops.
	task automatic test_output_pressure();
		gap_max  = 0;
		hold_req = HOLD_CYCLES;
		repeat (4) random_instruction();
		gap_max  = 4;
	endtask

	task automatic test_random_program();
		while (n_commands < RUN_TARGET) begin
			if ($urandom_range(0, 19) == 0)
				case ($urandom_range(0, 2))
					0:       gap_max = 0;
					1:       gap_max = 3;
					default: gap_max = 15;
				endcase
			if ($urandom_range(0, 3) != 0)
				random_instruction();
			else
				random_noise();
		end
	endtask

	// The stop status is sticky, so only one kind is taken per run.
	task automatic test_stop_condition();
		case ($urandom_range(0, 2))
			0: issue_instr(OP_HLT, 16'($urandom));
			1: issue_instr(8'($urandom_range(OP_LAST + 1, 255)), 16'($urandom));
			default: begin
				send_cmd(CMD_WRITE, DATA_BASE + 16'd40, 8'h00);
				issue_instr(OP_DIV, DATA_BASE + 16'd40);
			end
		endcase
		stop_seen = mach_st;
		send_cmd(CMD_EXEC, 16'($urandom), 8'($urandom));
	endtask

	// Steps must do nothing now; image writes and reads still work.
	task automatic test_stopped_machine();
		while (n_commands < ALL_TARGET) begin
			if ($urandom_range(0, 3) == 0)
				send_cmd(CMD_EXEC, 16'($urandom), 8'($urandom));
			else
				random_noise();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// s_tready stays low through the memory clear sweep; send_cmd waits on it
		test_image_access();
		test_each_opcode();
		test_output_pressure();
		test_random_program();
		test_stop_condition();
		test_stopped_machine();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d commands sent, %0d of them instruction steps; %0d results checked",
		         n_commands, n_steps, n_checked);
		$display("machine stopped with %s, then ran image traffic against the stopped machine",
		         stop_seen.name());
		if (n_fail == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

endmodule
